/* design/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Shared constants, register codes and tables for the chord sequencer with
// subharmonic divisor output.
// ----------------------------------------------------------------------------
package csd_pkg;

	localparam int HISTORY_DEPTH   = 32;
	localparam int NUM_DEGREES     = 7;
	localparam int MAX_SCALE_NOTES = 12;

	// notes packed in the scale register
	localparam int PACKED_NOTES = 12;
	localparam int PC_W         = 4;
	localparam int SCALE_W      = PACKED_NOTES * PC_W;

	localparam int DEG_W    = 3;
	localparam int CHANCE_W = 7;
	localparam int LEN_W    = 6;
	localparam int SIZE_W   = 4;
	localparam int INV_W    = 2;
	localparam int DIVR_W   = 4;
	localparam int VOICES   = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SCALE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEJAVU_CHANCE = 3'd0,
		REG_STAY_CHANCE   = 3'd1,
		REG_BRANCH_CHANCE = 3'd2,
		REG_LOOP_LEN      = 3'd3,
		REG_LOCKED        = 3'd4,
		REG_SCALE_SIZE    = 3'd5,
		REG_SCALE_PCS     = 3'd6
	} cfg_reg_t;

	localparam logic [LEN_W-1:0]   LOOP_LEN_RST   = 6'd8;
	localparam logic [SIZE_W-1:0]  SCALE_SIZE_RST = 4'd7;
	localparam logic [SCALE_W-1:0] SCALE_PCS_RST  = 48'h0000_0B97_5420;

	// pitch class nibble to subharmonic divisor; nibbles 12..15 fold mod 12
	function automatic logic [DIVR_W-1:0] divisor_of_pc(input logic [PC_W-1:0] pc);
		logic [DIVR_W-1:0] d;
		case (pc)
			4'd0:    d = 4'd1;
			4'd1:    d = 4'd15;
			4'd2:    d = 4'd7;
			4'd3:    d = 4'd7;
			4'd4:    d = 4'd13;
			4'd5:    d = 4'd3;
			4'd6:    d = 4'd11;
			4'd7:    d = 4'd11;
			4'd8:    d = 4'd5;
			4'd9:    d = 4'd5;
			4'd10:   d = 4'd9;
			4'd11:   d = 4'd1;
			4'd12:   d = 4'd1;
			4'd13:   d = 4'd15;
			4'd14:   d = 4'd7;
			4'd15:   d = 4'd7;
			default: d = 4'd1;
		endcase
		return d;
	endfunction

endpackage

/* design/chord_sequencer_subharmonic_divisors_core.sv */
// ----------------------------------------------------------------------------
// chord_sequencer_subharmonic_divisors_core
// Picks the next chord degree per clock tick (history replay, stay, branch or
// step), builds a rotated four-note chord of scale thirds and maps each note
// to a subharmonic divisor.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  tick     | tick_valid / tick_stall   | roll_dejavu, roll_stay, roll_branch,
//           |                           | roll_degree, inversion
//  result   | result_valid/result_stall | chord_degree, replayed, divisor_a..d
//  cfg      | cfg_write_enable          | cfg_index, cfg_data (no read-back)
//
// A request runs through two passes of the bit-serial remainder unit (history
// position mod loop length, then degree mod scale size), a history RAM access
// and its read state, a note state per voice and a hand-over state. One request
// is in flight at a time.
// A finished result sits in the output register; a new tick is taken while it
// waits, and only the hand-over stalls until the result is taken.
// Reset clears control state and the history valid bits and sets the configuration
// to its defaults; an entry never written reads as degree zero, so no clearing pass is needed.
//
module chord_sequencer_subharmonic_divisors_core #(
	parameter int HISTORY_DEPTH   = csd_pkg::HISTORY_DEPTH,
	parameter int NUM_DEGREES     = csd_pkg::NUM_DEGREES,
	parameter int MAX_SCALE_NOTES = csd_pkg::MAX_SCALE_NOTES
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_write_enable,
	input  logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csd_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  logic                             tick_valid,
	output logic                             tick_stall,
	input  logic [csd_pkg::CHANCE_W-1:0]     roll_dejavu,
	input  logic [csd_pkg::CHANCE_W-1:0]     roll_stay,
	input  logic [csd_pkg::CHANCE_W-1:0]     roll_branch,
	input  logic [csd_pkg::DEG_W-1:0]        roll_degree,
	input  logic [csd_pkg::INV_W-1:0]        inversion,

	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [csd_pkg::DEG_W-1:0]        chord_degree,
	output logic                             replayed,
	output logic [csd_pkg::DIVR_W-1:0]       divisor_a,
	output logic [csd_pkg::DIVR_W-1:0]       divisor_b,
	output logic [csd_pkg::DIVR_W-1:0]       divisor_c,
	output logic [csd_pkg::DIVR_W-1:0]       divisor_d
);

	// history position width; the remainder unit must hold DEPTH and a 6-bit
	// loop length plus one bit of headroom for the clamp compare
	localparam int SP_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int DW    = (SP_W + 1 > 7) ? SP_W + 1 : 7;
	localparam int CNT_W = $clog2(DW);
	localparam int SIZE_CAP = (MAX_SCALE_NOTES < csd_pkg::PACKED_NOTES) ?
		MAX_SCALE_NOTES : csd_pkg::PACKED_NOTES;
	localparam int SW = csd_pkg::SIZE_W;
	localparam int DGW = csd_pkg::DEG_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS_DIV,
		ST_MEM,
		ST_MEM_WAIT,
		ST_DEG_DIV,
		ST_NOTES,
		ST_FIN
	} state_t;

	// configuration
	logic [csd_pkg::CHANCE_W-1:0] dejavu_q, stay_q, branch_q;
	logic [csd_pkg::LEN_W-1:0]    loop_len_q;
	logic                         locked_q;
	logic [SW-1:0]                scale_size_q;
	logic [csd_pkg::SCALE_W-1:0]  scale_q;

	// sequencer state
	state_t                  state_q;
	logic [SP_W-1:0]         step_pos_q;
	logic [DGW-1:0]          cur_deg_q;
	logic                    replay_q;
	logic [DGW-1:0]          deg_q;
	logic [SP_W-1:0]         sp_wrap_q;
	logic [csd_pkg::INV_W-1:0] inv_q;

	// bit-serial remainder unit
	logic [DW-1:0]           div_num_q, div_den_q, div_rem_q;
	logic [CNT_W-1:0]        div_cnt_q;

	// note walk
	logic [SW-1:0]           note_q;
	logic [csd_pkg::INV_W-1:0] voice_q;
	logic [csd_pkg::DIVR_W-1:0] dvr_q [csd_pkg::VOICES];

	// history RAM and its valid bits
	logic [DGW-1:0]          hist_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic [DGW-1:0]          hist_rd_q;
	logic                    hist_rd_vld_q;
	logic                    hist_we, hist_re;
	logic [SP_W-1:0]         hist_addr;

	// result register
	logic                    res_valid_q;
	logic [DGW-1:0]          res_deg_q;
	logic                    res_replay_q;
	logic [csd_pkg::DIVR_W-1:0] res_dvr_q [csd_pkg::VOICES];

	// ---------------------------------------------------------------- decode
	logic [DW-1:0]   eff_len;
	logic [SW-1:0]   eff_size;
	logic            dec_replay;
	logic [DGW:0]    deg_roll_mod, deg_step;
	logic [DGW-1:0]  dec_next;
	logic [SP_W:0]   sp_inc;
	logic [SP_W-1:0] sp_wrap;

	always_comb begin
		eff_len = DW'(loop_len_q);
		if (eff_len == '0)
			eff_len = DW'(1);
		if (eff_len > DW'(HISTORY_DEPTH))
			eff_len = DW'(HISTORY_DEPTH);

		eff_size = scale_size_q;
		if (eff_size == '0)
			eff_size = SW'(1);
		if ({1'b0, eff_size} > (SW+1)'(SIZE_CAP))
			eff_size = SW'(SIZE_CAP);
	end

	always_comb begin
		dec_replay = locked_q | (roll_dejavu < dejavu_q);

		// random degree mod NUM_DEGREES: up to four folds of a 3-bit value
		deg_roll_mod = {1'b0, roll_degree};
		for (int k = 0; k < 4; k++) begin
			if (deg_roll_mod >= (DGW+1)'(NUM_DEGREES))
				deg_roll_mod = deg_roll_mod - (DGW+1)'(NUM_DEGREES);
		end

		deg_step = {1'b0, cur_deg_q} + (DGW+1)'(1);
		if (deg_step == (DGW+1)'(NUM_DEGREES))
			deg_step = '0;

		if (roll_stay < stay_q)
			dec_next = cur_deg_q;
		else if (roll_branch < branch_q)
			dec_next = deg_roll_mod[DGW-1:0];
		else
			dec_next = deg_step[DGW-1:0];

		sp_inc  = {1'b0, step_pos_q} + (SP_W+1)'(1);
		sp_wrap = (sp_inc == (SP_W+1)'(HISTORY_DEPTH)) ? '0 : sp_inc[SP_W-1:0];
	end

	// one restoring step of the remainder unit
	logic [DW:0]   div_trial;
	logic [DW-1:0] div_rem_nx;

	always_comb begin
		div_trial = {div_rem_q, div_num_q[DW-1]};
		if (div_trial >= {1'b0, div_den_q})
			div_trial = div_trial - {1'b0, div_den_q};
		div_rem_nx = div_trial[DW-1:0];
	end

	// note lookup and next third
	logic [csd_pkg::PC_W-1:0]   note_pc;
	logic [csd_pkg::DIVR_W-1:0] note_dvr;
	logic [SW:0]                note_nx;
	logic [csd_pkg::INV_W-1:0]  voice_slot;

	always_comb begin
		note_pc = '0;
		for (int k = 0; k < csd_pkg::PACKED_NOTES; k++) begin
			if (note_q == SW'(k))
				note_pc = scale_q[k*csd_pkg::PC_W +: csd_pkg::PC_W];
		end
		note_dvr = csd_pkg::divisor_of_pc(note_pc);

		// note < size, so two folds bring note + 2 back below size
		note_nx = {1'b0, note_q} + (SW+1)'(2);
		if (note_nx >= {1'b0, eff_size})
			note_nx = note_nx - {1'b0, eff_size};
		if (note_nx >= {1'b0, eff_size})
			note_nx = note_nx - {1'b0, eff_size};

		// left rotation: note i lands in voice (i - inversion) mod 4
		voice_slot = voice_q - inv_q;
	end

	// history RAM port control
	always_comb begin
		hist_addr = div_rem_q[SP_W-1:0];
		hist_we   = (state_q == ST_MEM) && !replay_q;
		hist_re   = (state_q == ST_MEM) && replay_q;
	end

	// ----------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dejavu_q     <= '0;
			stay_q       <= '0;
			branch_q     <= '0;
			loop_len_q   <= csd_pkg::LOOP_LEN_RST;
			locked_q     <= 1'b0;
			scale_size_q <= csd_pkg::SCALE_SIZE_RST;
			scale_q      <= csd_pkg::SCALE_PCS_RST;
		end else if (cfg_write_enable) begin
			case (csd_pkg::cfg_reg_t'(cfg_index))
				csd_pkg::REG_DEJAVU_CHANCE: dejavu_q <= cfg_data[csd_pkg::CHANCE_W-1:0];
				csd_pkg::REG_STAY_CHANCE:   stay_q   <= cfg_data[csd_pkg::CHANCE_W-1:0];
				csd_pkg::REG_BRANCH_CHANCE: branch_q <= cfg_data[csd_pkg::CHANCE_W-1:0];
				csd_pkg::REG_LOOP_LEN:      loop_len_q <= cfg_data[csd_pkg::LEN_W-1:0];
				csd_pkg::REG_LOCKED:        locked_q <= cfg_data[0];
				csd_pkg::REG_SCALE_SIZE:    scale_size_q <= cfg_data[SW-1:0];
				csd_pkg::REG_SCALE_PCS:     scale_q <= cfg_data[csd_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ history RAM
	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_addr] <= deg_q;
		if (hist_re)
			hist_rd_q <= hist_mem[hist_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q    <= '0;
			hist_rd_vld_q <= 1'b0;
		end else begin
			if (hist_we)
				hist_vld_q[hist_addr] <= 1'b1;
			if (hist_re)
				hist_rd_vld_q <= hist_vld_q[hist_addr];
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_pos_q   <= '0;
			cur_deg_q    <= '0;
			res_valid_q  <= 1'b0;
			replay_q     <= 1'b0;
			div_cnt_q    <= '0;
			voice_q      <= '0;
		end else begin
			// the hand-over state refills the register itself
			if (res_valid_q && !result_stall && state_q != ST_FIN)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						replay_q  <= dec_replay;
						deg_q     <= dec_next;
						sp_wrap_q <= sp_wrap;
						inv_q     <= inversion;
						div_num_q <= dec_replay ? DW'(sp_inc) : DW'(sp_wrap);
						div_den_q <= eff_len;
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_POS_DIV;
					end
				end
				ST_POS_DIV: begin
					div_rem_q <= div_rem_nx;
					div_num_q <= div_num_q << 1;
					div_cnt_q <= div_cnt_q + CNT_W'(1);
					if (div_cnt_q == CNT_W'(DW - 1))
						state_q <= ST_MEM;
				end
				ST_MEM: begin
					// replay keeps the position mod loop length, a fresh
					// choice keeps it mod the full depth
					step_pos_q <= replay_q ? div_rem_q[SP_W-1:0] : sp_wrap_q;
					state_q    <= ST_MEM_WAIT;
				end
				ST_MEM_WAIT: begin
					if (replay_q) begin
						deg_q     <= hist_rd_vld_q ? hist_rd_q : '0;
						div_num_q <= DW'(hist_rd_vld_q ? hist_rd_q : '0);
					end else begin
						div_num_q <= DW'(deg_q);
					end
					div_den_q <= DW'(eff_size);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DEG_DIV;
				end
				ST_DEG_DIV: begin
					div_rem_q <= div_rem_nx;
					div_num_q <= div_num_q << 1;
					div_cnt_q <= div_cnt_q + CNT_W'(1);
					if (div_cnt_q == CNT_W'(DW - 1)) begin
						note_q  <= div_rem_nx[SW-1:0];
						voice_q <= '0;
						state_q <= ST_NOTES;
					end
				end
				ST_NOTES: begin
					dvr_q[voice_slot] <= note_dvr;
					note_q  <= note_nx[SW-1:0];
					voice_q <= voice_q + csd_pkg::INV_W'(1);
					if (voice_q == csd_pkg::INV_W'(csd_pkg::VOICES - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!res_valid_q || !result_stall) begin
						res_valid_q  <= 1'b1;
						res_deg_q    <= deg_q;
						res_replay_q <= replay_q;
						res_dvr_q    <= dvr_q;
						cur_deg_q    <= deg_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign tick_stall   = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign chord_degree = res_deg_q;
	assign replayed     = res_replay_q;
	assign divisor_a    = res_dvr_q[0];
	assign divisor_b    = res_dvr_q[1];
	assign divisor_c    = res_dvr_q[2];
	assign divisor_d    = res_dvr_q[3];

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives clock ticks into the chord sequencer core and checks each chord
// request against a cycle-free software copy of the degree picker, history
// loop and divisor mapping. Directed ticks come first, then random phases
// with differing register settings and idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_HALF   = 6;
	localparam int RESET_CYC  = 8;
	localparam int CYCLE_CAP  = 400000;
	localparam int TAIL_CYC   = 40;
	localparam int PHASE_LEN  = 50;
	localparam int MAX_REPORT = 10;

	// index with no register behind it: writes must be ignored
	localparam logic [csd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// divisor for pitch classes 0..11, class i at bits 4i+3..4i
	localparam logic [12*csd_pkg::DIVR_W-1:0] PC_DIVISOR_TAB = {
		4'd1, 4'd9, 4'd5, 4'd5, 4'd11, 4'd11, 4'd3, 4'd13, 4'd7, 4'd7, 4'd15, 4'd1
	};

	typedef struct packed {
		logic [csd_pkg::CHANCE_W-1:0] roll_dejavu;
		logic [csd_pkg::CHANCE_W-1:0] roll_stay;
		logic [csd_pkg::CHANCE_W-1:0] roll_branch;
		logic [csd_pkg::DEG_W-1:0]    roll_degree;
		logic [csd_pkg::INV_W-1:0]    inversion;
	} tick_t;

	typedef struct packed {
		logic [csd_pkg::DEG_W-1:0]  degree;
		logic                       replayed;
		logic [csd_pkg::DIVR_W-1:0] div_a;
		logic [csd_pkg::DIVR_W-1:0] div_b;
		logic [csd_pkg::DIVR_W-1:0] div_c;
		logic [csd_pkg::DIVR_W-1:0] div_d;
	} chord_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                           cfg_write_enable = 1'b0;
	logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
	logic [csd_pkg::CFG_DATA_W-1:0] cfg_data         = '0;

	logic                         tick_valid  = 1'b0;
	logic                         tick_stall;
	logic [csd_pkg::CHANCE_W-1:0] roll_dejavu = '0;
	logic [csd_pkg::CHANCE_W-1:0] roll_stay   = '0;
	logic [csd_pkg::CHANCE_W-1:0] roll_branch = '0;
	logic [csd_pkg::DEG_W-1:0]    roll_degree = '0;
	logic [csd_pkg::INV_W-1:0]    inversion   = '0;

	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [csd_pkg::DEG_W-1:0]  chord_degree;
	logic                       replayed;
	logic [csd_pkg::DIVR_W-1:0] divisor_a;
	logic [csd_pkg::DIVR_W-1:0] divisor_b;
	logic [csd_pkg::DIVR_W-1:0] divisor_c;
	logic [csd_pkg::DIVR_W-1:0] divisor_d;

	chord_sequencer_subharmonic_divisors_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.tick_valid       (tick_valid),
		.tick_stall       (tick_stall),
		.roll_dejavu      (roll_dejavu),
		.roll_stay        (roll_stay),
		.roll_branch      (roll_branch),
		.roll_degree      (roll_degree),
		.inversion        (inversion),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.chord_degree     (chord_degree),
		.replayed         (replayed),
		.divisor_a        (divisor_a),
		.divisor_b        (divisor_b),
		.divisor_c        (divisor_c),
		.divisor_d        (divisor_d)
	);

	// ------------------------------------------------------------------------
	// Shadow of the block: register copies and sequencer state
	// ------------------------------------------------------------------------
	logic [csd_pkg::CHANCE_W-1:0] sh_dejavu = '0;
	logic [csd_pkg::CHANCE_W-1:0] sh_stay   = '0;
	logic [csd_pkg::CHANCE_W-1:0] sh_branch = '0;
	logic [csd_pkg::LEN_W-1:0]    sh_loop   = csd_pkg::LOOP_LEN_RST;
	logic                         sh_locked = 1'b0;
	logic [csd_pkg::SIZE_W-1:0]   sh_size   = csd_pkg::SCALE_SIZE_RST;
	logic [csd_pkg::SCALE_W-1:0]  sh_scale  = csd_pkg::SCALE_PCS_RST;

	int                        hist_pos = 0;
	int                        cur_deg  = 0;
	logic [csd_pkg::DEG_W-1:0] hist_deg [csd_pkg::HISTORY_DEPTH];

	tick_t  ticks_to_send [$];
	chord_t chords_due [$];

	// percentages steering the idling of either side
	int send_gap_pct = 0;
	int stall_pct    = 0;

	// set at each rising edge when a tick request went in
	logic tick_fired = 1'b0;

	int cycle_count = 0;
	int bad_results = 0;

	initial begin : clock_gen
		forever #(CLK_HALF) clk = ~clk;
	end

	// Works out the chord for one tick and moves the shadow state on.
	// Replay walks the history mod the loop length; a fresh pick advances the
	// position mod the full depth and lands in slot (pos mod loop length).
	function automatic chord_t predict_chord(input tick_t t);
		chord_t r;
		int span, size, deg, idx, pc;
		int note [4];
		logic [csd_pkg::DIVR_W-1:0] divs [4];
		span = (sh_loop == 0) ? 1 :
			(sh_loop > csd_pkg::HISTORY_DEPTH) ? csd_pkg::HISTORY_DEPTH : int'(sh_loop);
		if (sh_locked || t.roll_dejavu < sh_dejavu) begin
			hist_pos   = (hist_pos + 1) % span;
			deg        = int'(hist_deg[hist_pos % csd_pkg::HISTORY_DEPTH]);
			r.replayed = 1'b1;
		end else begin
			if (t.roll_stay < sh_stay)
				deg = cur_deg;
			else if (t.roll_branch < sh_branch)
				deg = t.roll_degree % csd_pkg::NUM_DEGREES;
			else
				deg = (cur_deg + 1) % csd_pkg::NUM_DEGREES;
			hist_pos = (hist_pos + 1) % csd_pkg::HISTORY_DEPTH;
			hist_deg[(hist_pos % span) % csd_pkg::HISTORY_DEPTH] = csd_pkg::DEG_W'(deg);
			r.replayed = 1'b0;
		end
		cur_deg = deg;
		size = (sh_size == 0) ? 1 : (sh_size > 12) ? 12 : int'(sh_size);
		if (size > csd_pkg::MAX_SCALE_NOTES)
			size = csd_pkg::MAX_SCALE_NOTES;
		for (int i = 0; i < 4; i++)
			note[i] = (2 * i + deg) % size;
		for (int i = 0; i < 4; i++) begin
			idx     = note[(i + t.inversion) & 3];
			pc      = int'(sh_scale[csd_pkg::PC_W*idx +: csd_pkg::PC_W]) % 12;
			divs[i] = PC_DIVISOR_TAB[csd_pkg::DIVR_W*pc +: csd_pkg::DIVR_W];
		end
		r.degree = csd_pkg::DEG_W'(deg);
		r.div_a  = divs[0];
		r.div_b  = divs[1];
		r.div_c  = divs[2];
		r.div_d  = divs[3];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Tick driver: new payload only once the previous request has gone in
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : drive_ticks
		logic  send;
		tick_t t;
		if (arst_n) begin
			if (!tick_valid || tick_fired) begin
				send = ticks_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct;
				if (send) begin
					t = ticks_to_send.pop_front();
					roll_dejavu <= t.roll_dejavu;
					roll_stay   <= t.roll_stay;
					roll_branch <= t.roll_branch;
					roll_degree <= t.roll_degree;
					inversion   <= t.inversion;
				end
				tick_valid <= send;
			end
			result_stall <= $urandom_range(99) < stall_pct;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predicts on tick acceptance, checks on result acceptance
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_chords
		chord_t got, want;
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("testbench: done, errors");
			$finish;
		end else if (arst_n) begin
			tick_fired = tick_valid && !tick_stall;
			if (tick_fired)
				chords_due.push_back(predict_chord({roll_dejavu, roll_stay, roll_branch,
					roll_degree, inversion}));
			if (result_valid === 1'b1 && !result_stall) begin
				got = {chord_degree, replayed, divisor_a, divisor_b, divisor_c, divisor_d};
				if (chords_due.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_REPORT)
						$display("unexpected chord: deg %0d rep %0d div %0d %0d %0d %0d",
							got.degree, got.replayed, got.div_a, got.div_b, got.div_c, got.div_d);
				end else begin
					want = chords_due.pop_front();
					if (got.degree !== want.degree || got.replayed !== want.replayed ||
						got.div_a !== want.div_a || got.div_b !== want.div_b ||
						got.div_c !== want.div_c || got.div_d !== want.div_d) begin
						bad_results++;
						if (bad_results <= MAX_REPORT)
							$display({"chord mismatch: exp deg %0d rep %0d div %0d %0d %0d %0d,",
								" got deg %0d rep %0d div %0d %0d %0d %0d"},
								want.degree, want.replayed, want.div_a, want.div_b,
								want.div_c, want.div_d, got.degree, got.replayed,
								got.div_a, got.div_b, got.div_c, got.div_d);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// register write; the shadow keeps only the bits the register holds
	task automatic write_reg(input logic [csd_pkg::CFG_IDX_W-1:0] idx,
			input logic [csd_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write_enable <= 1'b1;
		cfg_index        <= idx;
		cfg_data         <= value;
		@(negedge clk);
		cfg_write_enable <= 1'b0;
		case (idx)
			csd_pkg::REG_DEJAVU_CHANCE: sh_dejavu = value[csd_pkg::CHANCE_W-1:0];
			csd_pkg::REG_STAY_CHANCE:   sh_stay   = value[csd_pkg::CHANCE_W-1:0];
			csd_pkg::REG_BRANCH_CHANCE: sh_branch = value[csd_pkg::CHANCE_W-1:0];
			csd_pkg::REG_LOOP_LEN:      sh_loop   = value[csd_pkg::LEN_W-1:0];
			csd_pkg::REG_LOCKED:        sh_locked = value[0];
			csd_pkg::REG_SCALE_SIZE:    sh_size   = value[csd_pkg::SIZE_W-1:0];
			csd_pkg::REG_SCALE_PCS:     sh_scale  = value[csd_pkg::SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_tick(input int rd, input int rs, input int rb, input int dg,
			input int inv);
		ticks_to_send.push_back({rd[csd_pkg::CHANCE_W-1:0], rs[csd_pkg::CHANCE_W-1:0],
			rb[csd_pkg::CHANCE_W-1:0], dg[csd_pkg::DEG_W-1:0], inv[csd_pkg::INV_W-1:0]});
	endtask

	// hold the sender until every queued request has come back
	task automatic wait_drained();
		while (ticks_to_send.size() != 0 || tick_valid || chords_due.size() != 0)
			@(posedge clk);
	endtask

	// half the time, set bits above the register's width to check they are dropped
	function automatic logic [csd_pkg::CFG_DATA_W-1:0] garble(
			input logic [csd_pkg::CFG_DATA_W-1:0] v, input int w);
		logic [csd_pkg::CFG_DATA_W-1:0] junk;
		junk = csd_pkg::CFG_DATA_W'({$urandom(), $urandom()});
		return $urandom_range(1) ? (v | (junk << w)) : v;
	endfunction

	function automatic int pick_chance();
		case ($urandom_range(5))
			0:       return 0;
			1:       return 100;
			2:       return 127;
			default: return $urandom_range(100);
		endcase
	endfunction

	// mostly in 0..99, now and then above the nominal range
	function automatic int pick_roll();
		return ($urandom_range(9) == 0) ? $urandom_range(127, 100) : $urandom_range(99);
	endfunction

	task automatic shuffle_config();
		int loop_pick, size_pick;
		logic [csd_pkg::SCALE_W-1:0] scale;
		case ($urandom_range(5))
			0:       loop_pick = 0;
			1:       loop_pick = 1;
			2:       loop_pick = csd_pkg::HISTORY_DEPTH;
			3:       loop_pick = $urandom_range(63, csd_pkg::HISTORY_DEPTH + 1);
			default: loop_pick = $urandom_range(csd_pkg::HISTORY_DEPTH - 1, 2);
		endcase
		size_pick = ($urandom_range(3) == 0) ? $urandom_range(15) : 7;
		if ($urandom_range(3) == 0) begin
			scale = csd_pkg::SCALE_W'({$urandom(), $urandom()});
		end else begin
			for (int i = 0; i < csd_pkg::PACKED_NOTES; i++)
				scale[csd_pkg::PC_W*i +: csd_pkg::PC_W] = csd_pkg::PC_W'($urandom_range(11));
		end
		write_reg(csd_pkg::REG_DEJAVU_CHANCE,
			garble(csd_pkg::CFG_DATA_W'(pick_chance()), csd_pkg::CHANCE_W));
		write_reg(csd_pkg::REG_STAY_CHANCE,
			garble(csd_pkg::CFG_DATA_W'(pick_chance()), csd_pkg::CHANCE_W));
		write_reg(csd_pkg::REG_BRANCH_CHANCE,
			garble(csd_pkg::CFG_DATA_W'(pick_chance()), csd_pkg::CHANCE_W));
		write_reg(csd_pkg::REG_LOOP_LEN,
			garble(csd_pkg::CFG_DATA_W'(loop_pick), csd_pkg::LEN_W));
		write_reg(csd_pkg::REG_LOCKED,
			garble(csd_pkg::CFG_DATA_W'($urandom_range(4) == 0), 1));
		write_reg(csd_pkg::REG_SCALE_SIZE,
			garble(csd_pkg::CFG_DATA_W'(size_pick), csd_pkg::SIZE_W));
		write_reg(csd_pkg::REG_SCALE_PCS, scale);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		for (int i = 0; i < csd_pkg::HISTORY_DEPTH; i++)
			hist_deg[i] = '0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: all chances zero, so every tick steps the degree;
		// rolls and the random degree at both ends, every inversion
		queue_tick(0,   0,   0,   0, 0);
		queue_tick(127, 127, 127, 7, 1);
		queue_tick(99,  99,  99,  6, 2);
		queue_tick(1,   0,   127, 3, 3);
		wait_drained();

		// even odds on each choice, short loop; junk above the chance field
		write_reg(csd_pkg::REG_DEJAVU_CHANCE, 48'hFFFF_FFFF_FF32);
		write_reg(csd_pkg::REG_STAY_CHANCE,   50);
		write_reg(csd_pkg::REG_BRANCH_CHANCE, 50);
		write_reg(csd_pkg::REG_LOOP_LEN,      5);
		queue_tick(49,  99,  99,  0, 0);   // replay
		queue_tick(50,  49,  99,  0, 1);   // stay
		queue_tick(50,  50,  49,  7, 2);   // branch, degree 7 folds to 0
		queue_tick(50,  50,  49,  6, 3);   // branch to the top degree
		queue_tick(50,  50,  50,  2, 0);   // step
		queue_tick(120, 120, 120, 5, 1);   // rolls over 99 lose every chance
		queue_tick(0,   0,   0,   2, 2);   // replay again
		queue_tick(100, 0,   0,   4, 3);   // stay
		queue_tick(99,  127, 0,   1, 0);   // branch
		wait_drained();

		// locked loop longer than the history, wide scale with nibbles 12..15;
		// a write to the unused index must change nothing
		write_reg(csd_pkg::REG_LOCKED,     1);
		write_reg(csd_pkg::REG_LOOP_LEN,   40);
		write_reg(csd_pkg::REG_SCALE_SIZE, 15);
		write_reg(csd_pkg::REG_SCALE_PCS,  48'hFEDC_BA98_7654);
		write_reg(REG_NONE,                48'hFFFF_FFFF_FFFF);
		queue_tick(127, 127, 127, 7, 0);
		queue_tick(0,   0,   0,   0, 1);
		queue_tick(64,  3,   17,  5, 2);
		queue_tick(99,  99,  99,  1, 3);
		wait_drained();

		// zero loop length and zero scale size; stay and branch chances at their ceiling
		write_reg(csd_pkg::REG_LOCKED,        0);
		write_reg(csd_pkg::REG_LOOP_LEN,      0);
		write_reg(csd_pkg::REG_SCALE_SIZE,    0);
		write_reg(csd_pkg::REG_DEJAVU_CHANCE, 0);
		write_reg(csd_pkg::REG_STAY_CHANCE,   127);
		write_reg(csd_pkg::REG_BRANCH_CHANCE, 127);
		queue_tick(0, 126, 0,   3, 0);     // stay
		queue_tick(0, 127, 126, 3, 1);     // branch
		queue_tick(0, 127, 127, 3, 2);     // step: equal roll never wins
		wait_drained();

		// random phases: no idling, sender gaps, receiver stalls, light both
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 61; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 61; end
				default: begin send_gap_pct = 8; stall_pct = 8; end
			endcase
			shuffle_config();
			for (int n = 0; n < PHASE_LEN; n++)
				queue_tick(pick_roll(), pick_roll(), pick_roll(),
					$urandom_range(7), $urandom_range(3));
			wait_drained();
		end

		// let any stray result surface before the verdict
		repeat (TAIL_CYC) @(posedge clk);
		if (bad_results == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
